/* design/ortb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ortb_pkg
// Types and constants shared by the overwrite ring trace buffer.
// ----------------------------------------------------------------------------
package ortb_pkg;

	localparam int unsigned RING_DEPTH_DEF = 4096;
	localparam int unsigned MAX_DRAIN_DEF  = 64;
	localparam int unsigned BUF_SIZE_RST   = 4096;

	localparam int unsigned REQ_W   = 2;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned CNT_W   = 7;
	localparam int unsigned CFG_W   = 13;
	localparam int unsigned FILL_W  = 12;
	localparam int unsigned TOTAL_W = 32;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH  = 2'd0,
		REQ_DRAIN = 2'd1,
		REQ_PANIC = 2'd2,
		REQ_NONE  = 2'd3
	} ortb_req_t;

	typedef enum logic {
		ST_IDLE,
		ST_DRAIN
	} ortb_state_t;

endpackage
`default_nettype wire

/* design/overwrite_ring_trace_buffer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// overwrite_ring_trace_buffer
// Byte trace log in a ring; oldest word overwritten when full, drained in
// order on request, with sticky panic mark and running push count.
// ----------------------------------------------------------------------------
// channel   dir  handshake             payload
// in        in   in_valid / in_ready   req_type, byte_in, drain_count
// out       out  out_valid / out_ready data_out, data_valid, last,
//                                      fill_level, total_pushed, panic_flag
// cfg       in   cfg_we                cfg_wdata (buffer_size)
//
// Push, panic and status requests: one word in per cycle while in_ready is
// high; the result passes the result stage, then the output register.
// Drain of n bytes: one ring memory read per byte; no new word is
// taken until the last read is issued.
// Reset empties the log and clears counters; no memory clear is needed.
// A stalled output holds the result stage, which holds the input side.
// ----------------------------------------------------------------------------
module overwrite_ring_trace_buffer
	import ortb_pkg::*;
#(
	parameter int unsigned RING_DEPTH = RING_DEPTH_DEF,
	parameter int unsigned MAX_DRAIN  = MAX_DRAIN_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,

	input  wire logic                 cfg_we,
	input  wire logic [CFG_W-1:0]     cfg_wdata,

	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [REQ_W-1:0]     req_type,
	input  wire logic [BYTE_W-1:0]    byte_in,
	input  wire logic [CNT_W-1:0]     drain_count,

	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [BYTE_W-1:0]         data_out,
	output logic                      data_valid,
	output logic                      last,
	output logic [FILL_W-1:0]         fill_level,
	output logic [TOTAL_W-1:0]        total_pushed,
	output logic                      panic_flag
);

	localparam int unsigned IDX_W = $clog2(RING_DEPTH);
	localparam int unsigned SZ_W  = $clog2(RING_DEPTH + 1);
	localparam int unsigned SIZE_RST =
		(BUF_SIZE_RST > RING_DEPTH) ? RING_DEPTH : BUF_SIZE_RST;

	// ring and indexes
	logic [BYTE_W-1:0] ring_mem [RING_DEPTH];
	logic [SZ_W-1:0]   size_q;
	logic [IDX_W-1:0]  rd_idx_q;
	logic [IDX_W-1:0]  wr_idx_q;
	logic [IDX_W-1:0]  fill_q;
	logic [TOTAL_W-1:0] total_q;
	logic              panic_q;
	logic [CNT_W-1:0]  rem_q;
	ortb_state_t       state_q;
	ortb_state_t       state_nx;

	// result stage
	logic              valid_s1;
	logic              is_data_s1;
	logic              last_s1;
	logic [IDX_W-1:0]  fill_s1;
	logic [TOTAL_W-1:0] total_s1;
	logic              panic_s1;
	logic [BYTE_W-1:0] rd_data_s1;

	// output register
	logic              out_valid_q;
	logic [BYTE_W-1:0] data_q;
	logic              data_valid_q;
	logic              last_q;
	logic [FILL_W-1:0] fill_out_q;
	logic [TOTAL_W-1:0] total_out_q;
	logic              panic_out_q;

	logic              out_free;
	logic              s1_adv;
	logic              s1_free;
	logic              acc;
	logic              push_go;
	logic              drain_go;
	logic              issue;
	logic              status_go;
	logic              full;
	logic [IDX_W-1:0]  rd_next;
	logic [IDX_W-1:0]  wr_next;
	logic [CNT_W-1:0]  cnt_lim;
	logic [CNT_W-1:0]  n_acc;
	logic [CNT_W-1:0]  cur_n;
	logic [IDX_W-1:0]  fill_push;
	logic [TOTAL_W-1:0] total_push;
	logic [SZ_W-1:0]   size_wr;

	function automatic logic [IDX_W-1:0] next_slot(
		input logic [IDX_W-1:0] i,
		input logic [SZ_W-1:0]  sz
	);
		logic [SZ_W:0] n;
		n = (SZ_W+1)'(i) + (SZ_W+1)'(1);
		return (n >= (SZ_W+1)'(sz)) ? '0 : IDX_W'(n);
	endfunction

	assign out_free = !out_valid_q || out_ready;
	assign s1_adv   = valid_s1 && out_free;
	assign s1_free  = !valid_s1 || s1_adv;
	assign in_ready = (state_q == ST_IDLE) && s1_free;
	assign acc      = in_valid && in_ready;

	assign rd_next = next_slot(rd_idx_q, size_q);
	assign wr_next = next_slot(wr_idx_q, size_q);
	assign full    = (fill_q == IDX_W'(size_q - SZ_W'(1)));

	assign cnt_lim = (32'(drain_count) > MAX_DRAIN) ? CNT_W'(MAX_DRAIN) : drain_count;
	assign n_acc   = (32'(fill_q) < 32'(cnt_lim)) ? CNT_W'(fill_q) : cnt_lim;

	assign fill_push  = full ? fill_q : fill_q + IDX_W'(1);
	assign total_push = total_q + TOTAL_W'(1);

	always_comb begin
		if (32'(cfg_wdata) < 32'd2) begin
			size_wr = SZ_W'(2);
		end else if (32'(cfg_wdata) > RING_DEPTH) begin
			size_wr = SZ_W'(RING_DEPTH);
		end else begin
			size_wr = SZ_W'(cfg_wdata);
		end
	end

	// control decode
	always_comb begin
		push_go   = acc && (req_type == REQ_PUSH) && (byte_in != '0);
		drain_go  = acc && (req_type == REQ_DRAIN) && (n_acc != '0);
		status_go = acc && !drain_go;
		issue     = drain_go || ((state_q == ST_DRAIN) && s1_free);
		cur_n     = (state_q == ST_DRAIN) ? rem_q : n_acc;
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (drain_go && (n_acc != CNT_W'(1))) begin
					state_nx = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (issue && (rem_q == CNT_W'(1))) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			size_q   <= SZ_W'(SIZE_RST);
			rd_idx_q <= '0;
			wr_idx_q <= IDX_W'(1);
			fill_q   <= '0;
			total_q  <= '0;
			panic_q  <= 1'b0;
			rem_q    <= '0;
		end else begin
			state_q <= state_nx;
			if (issue) begin
				rem_q <= cur_n - CNT_W'(1);
			end
			if (acc && (req_type == REQ_PANIC)) begin
				panic_q <= 1'b1;
			end
			if (cfg_we) begin
				size_q   <= size_wr;
				rd_idx_q <= '0;
				wr_idx_q <= IDX_W'(1);
				fill_q   <= '0;
			end else if (push_go) begin
				if (full) begin
					rd_idx_q <= rd_next;
				end
				wr_idx_q <= wr_next;
				fill_q   <= fill_push;
				total_q  <= total_push;
			end else if (issue) begin
				rd_idx_q <= rd_next;
				fill_q   <= fill_q - IDX_W'(1);
			end
		end
	end

	// ring memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (push_go) begin
			ring_mem[wr_idx_q] <= byte_in;
		end
		if (issue) begin
			rd_data_s1 <= ring_mem[rd_next];
		end
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (issue || status_go) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			is_data_s1 <= 1'b1;
			last_s1    <= (cur_n == CNT_W'(1));
			fill_s1    <= fill_q - IDX_W'(1);
			total_s1   <= total_q;
			panic_s1   <= panic_q;
		end else if (status_go) begin
			is_data_s1 <= 1'b0;
			last_s1    <= 1'b1;
			fill_s1    <= push_go ? fill_push : fill_q;
			total_s1   <= push_go ? total_push : total_q;
			panic_s1   <= panic_q || (req_type == REQ_PANIC);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			data_q       <= is_data_s1 ? rd_data_s1 : '0;
			data_valid_q <= is_data_s1;
			last_q       <= last_s1;
			fill_out_q   <= FILL_W'(fill_s1);
			total_out_q  <= total_s1;
			panic_out_q  <= panic_s1;
		end
	end

	assign out_valid    = out_valid_q;
	assign data_out     = data_q;
	assign data_valid   = data_valid_q;
	assign last         = last_q;
	assign fill_level   = fill_out_q;
	assign total_pushed = total_out_q;
	assign panic_flag   = panic_out_q;

endmodule
`default_nettype wire
